// ----- src/alrc_pkg.sv -----
// Package: pattern tables, codes and helper functions for the AT response line classifier.
package alrc_pkg;

    localparam int NPAT    = 18;
    localparam int PAT_MAX = 12;

    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [7:0] POS_SAT = 8'd255;

    // Pattern text, right-justified: char i of a pattern of length L sits at byte L-1-i.
    // 0-5 exact finals, 6-7 final prefixes, 8-17 URC prefixes.
    localparam logic [8*PAT_MAX-1:0] PAT_TEXT [NPAT] = '{
        "OK", "ERROR", "NO CARRIER", "NO DIALTONE", "BUSY", "NO ANSWER",
        "+CME ERROR", "+CMS ERROR",
        "RING", "+CLIP:", "VOICE CALL:", {"MISSED", "_CALL:"}, "NO CARRIER",
        "+CMTI:", "+CEREG:", "+CREG:", "+CPIN:", "+SIMCARD:"
    };

    localparam logic [3:0] PAT_LEN [NPAT] = '{
        4'd2, 4'd5, 4'd10, 4'd11, 4'd4, 4'd9,
        4'd10, 4'd10,
        4'd4, 4'd6, 4'd11, 4'd12, 4'd10,
        4'd6, 4'd7, 4'd6, 4'd6, 4'd9
    };

    localparam int N_EXACT = 6;
    localparam int N_FINAL = 8;

    // Final result codes
    localparam logic [3:0] FC_NONE       = 4'd0;
    localparam logic [3:0] FC_NO_CARRIER = 4'd3;
    localparam logic [3:0] FC_BUSY       = 4'd5;
    localparam logic [3:0] FC_NO_ANSWER  = 4'd6;

    // URC codes
    localparam logic [3:0] UC_NONE = 4'd0;
    localparam logic [3:0] UC_LAST = 4'd10;

    typedef struct packed {
        logic       is_final;
        logic [3:0] final_code;
        logic       is_urc;
        logic [3:0] urc_code;
        logic       route_to_handler;
    } class_t;

    // The ten whitespace bytes: 0x09-0x0D, 0x1C-0x1F, 0x20
    function automatic logic ws_byte(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D) || (b >= 8'h1C && b <= 8'h1F);
    endfunction

    // Mask of patterns that still agree with byte b at offset pos
    function automatic logic [NPAT-1:0] pat_keep(input logic [7:0] pos, input logic [7:0] b);
        logic [NPAT-1:0] keep;
        logic [3:0]      idx;
        keep = '1;
        for (int p = 0; p < NPAT; p++)
        begin
            idx = PAT_LEN[p] - 4'd1 - pos[3:0];
            if (pos < {4'd0, PAT_LEN[p]} && PAT_TEXT[p][{idx, 3'b000} +: 8] != b)
            begin
                keep[p] = 1'b0;
            end
        end
        return keep;
    endfunction

endpackage

// ----- src/alrc_classify.sv -----
// Line classifier: final code, URC code and routing from the state at the last content byte.
module alrc_classify
    import alrc_pkg::*;
(
    input  logic [NPAT-1:0] alive,
    input  logic [7:0]      last_pos,
    output class_t          cls
);

    logic [3:0] fc;
    logic [3:0] uc;

    always_comb
    begin
        fc = FC_NONE;
        uc = UC_NONE;
        for (int p = 0; p < N_FINAL; p++)
        begin
            if (fc == FC_NONE && alive[p])
            begin
                if ((p < N_EXACT) ? (last_pos == {4'd0, PAT_LEN[p]})
                                  : (last_pos >= {4'd0, PAT_LEN[p]}))
                begin
                    fc = 4'(p + 1);
                end
            end
        end
        for (int p = N_FINAL; p < NPAT; p++)
        begin
            if (uc == UC_NONE && alive[p] && last_pos >= {4'd0, PAT_LEN[p]})
            begin
                uc = 4'(p - N_FINAL + 1);
            end
        end
    end

    always_comb
    begin
        cls.is_final         = (fc != FC_NONE);
        cls.final_code       = fc;
        cls.is_urc           = (uc != UC_NONE);
        cls.urc_code         = uc;
        cls.route_to_handler = (uc != UC_NONE) || (fc == FC_NO_CARRIER) ||
                               (fc == FC_BUSY) || (fc == FC_NO_ANSWER);
    end

endmodule

// ----- src/at_response_line_classifier_core.sv -----
// Top level: AT response line classifier, one received byte per request.
// A newline request, once accepted, passes the input register and then the result
// register before out_valid rises. Throughput: one byte per cycle; the
// input stalls only while a newline closing a line waits behind a stalled result.
// Reset (rst_n, async, active low) clears the line state, empties both
// registers and deasserts out_valid; pattern tracking starts all alive.
module at_response_line_classifier_core
    import alrc_pkg::*;
#(
    parameter int MAX_LINE = 256
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_final,
    output logic [3:0] final_code,
    output logic       is_urc,
    output logic [3:0] urc_code,
    output logic       route_to_handler,
    output logic [7:0] line_length,
    output logic       had_non_ascii
);

    localparam int LEN_W = $clog2(MAX_LINE);

    // Input register
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;

    // Line state
    logic             started_reg,   started_next;
    logic [7:0]       pos_reg,       pos_next;
    logic [7:0]       last_pos_reg,  last_pos_next;
    logic [NPAT-1:0]  alive_reg,     alive_next;
    logic [NPAT-1:0]  alive_last_reg, alive_last_next;
    logic [LEN_W-1:0] dec_reg,       dec_next;
    logic [LEN_W-1:0] dec_last_reg,  dec_last_next;
    logic             stopped_reg,   stopped_next;
    logic             non_ascii_reg, non_ascii_next;

    // Result register
    logic       out_valid_reg, out_valid_next;
    class_t     cls_reg;
    logic [7:0] len_reg;
    logic       had_reg;

    logic             is_lf;
    logic             is_ws;
    logic             emit;
    logic             out_free;
    logic             fire;
    logic             in_accept;
    logic [LEN_W:0]   dec_sum;
    logic [LEN_W+7:0] dec_ext;
    logic [7:0]       len_clamped;
    class_t           cls;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_lf     = (s1_byte_reg == CHAR_LF);
    assign is_ws     = ws_byte(s1_byte_reg);
    // Only a newline closing a non-empty line produces a result
    assign emit      = is_lf && started_reg;
    assign fire      = s1_valid_reg && (!emit || out_free);
    assign in_stall  = s1_valid_reg && !fire;

    // Candidate decoded length; a high-bit byte counts three
    assign dec_sum = {1'b0, dec_reg} + (s1_byte_reg[7] ? (LEN_W+1)'(3) : (LEN_W+1)'(1));

    // Length clamps to 255 for wide MAX_LINE
    assign dec_ext     = (LEN_W+8)'(dec_last_reg);
    assign len_clamped = (dec_ext > (LEN_W+8)'(255)) ? 8'hFF : dec_ext[7:0];

    alrc_classify u_classify (
        .alive    (alive_last_reg),
        .last_pos (last_pos_reg),
        .cls      (cls)
    );

    assign s1_valid_next  = in_accept ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = (fire && emit) ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_comb
    begin
        started_next    = started_reg;
        pos_next        = pos_reg;
        last_pos_next   = last_pos_reg;
        alive_next      = alive_reg;
        alive_last_next = alive_last_reg;
        dec_next        = dec_reg;
        dec_last_next   = dec_last_reg;
        stopped_next    = stopped_reg;
        non_ascii_next  = non_ascii_reg;
        if (fire)
        begin
            if (is_lf)
            begin
                // End of line: clear for the next one
                started_next    = 1'b0;
                pos_next        = '0;
                last_pos_next   = '0;
                alive_next      = '1;
                alive_last_next = '1;
                dec_next        = '0;
                dec_last_next   = '0;
                stopped_next    = 1'b0;
                non_ascii_next  = 1'b0;
            end
            else if (started_reg || !is_ws)
            begin
                started_next = 1'b1;
                alive_next   = alive_reg & pat_keep(pos_reg, s1_byte_reg);
                pos_next     = (pos_reg < POS_SAT) ? pos_reg + 8'd1 : pos_reg;
                if (!stopped_reg)
                begin
                    if (dec_sum >= (LEN_W+1)'(MAX_LINE))
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        dec_next = dec_sum[LEN_W-1:0];
                    end
                end
                if (s1_byte_reg[7])
                begin
                    non_ascii_next = 1'b1;
                end
                // Snapshot at each content byte, so trailing whitespace drops out
                if (!is_ws)
                begin
                    last_pos_next   = pos_next;
                    alive_last_next = alive_next;
                    dec_last_next   = dec_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            started_reg    <= 1'b0;
            pos_reg        <= '0;
            last_pos_reg   <= '0;
            alive_reg      <= '1;
            alive_last_reg <= '1;
            dec_reg        <= '0;
            dec_last_reg   <= '0;
            stopped_reg    <= 1'b0;
            non_ascii_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            started_reg    <= started_next;
            pos_reg        <= pos_next;
            last_pos_reg   <= last_pos_next;
            alive_reg      <= alive_next;
            alive_last_reg <= alive_last_next;
            dec_reg        <= dec_next;
            dec_last_reg   <= dec_last_next;
            stopped_reg    <= stopped_next;
            non_ascii_reg  <= non_ascii_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (fire && emit)
        begin
            cls_reg <= cls;
            len_reg <= len_clamped;
            had_reg <= non_ascii_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign is_final         = cls_reg.is_final;
    assign final_code       = cls_reg.final_code;
    assign is_urc           = cls_reg.is_urc;
    assign urc_code         = cls_reg.urc_code;
    assign route_to_handler = cls_reg.route_to_handler;
    assign line_length      = len_reg;
    assign had_non_ascii    = had_reg;

`ifndef SYNTHESIS
    // A reported line always has content, so a nonzero length
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (len_reg != 8'd0))
        else $error("result with zero line length");

    // A newline that is consumed leaves the line state cleared
    a_lf_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_lf) |=> (!started_reg && dec_reg == '0 && alive_reg == '1))
        else $error("line state not cleared after newline");

    // URC code stays within the prefix list
    a_urc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cls_reg.is_urc) |->
            (cls_reg.urc_code != UC_NONE && cls_reg.urc_code <= UC_LAST))
        else $error("URC code out of range");
`endif

endmodule
